// ===== hw/rtl/pis_pkg.sv =====
package pis_pkg;

    localparam int unsigned AW = 5;

    typedef enum logic [2:0] {
        REG_GRAVITY     = 3'd0,
        REG_DAMPING     = 3'd1,
        REG_RESTITUTION = 3'd2,
        REG_FRICTION    = 3'd3,
        REG_FLOOR       = 3'd4,
        REG_TIME_STEP   = 3'd5
    } reg_idx_t;

    localparam logic [31:0] GRAVITY_RST     = 32'hFFEE_0000;
    localparam logic [16:0] DAMPING_RST     = 17'd64553;
    localparam logic [16:0] RESTITUTION_RST = 17'd29491;
    localparam logic [16:0] FRICTION_RST    = 17'd57672;
    localparam logic [31:0] FLOOR_RST       = 32'd0;
    localparam logic [16:0] TIME_STEP_RST   = 17'd1092;

    localparam logic [16:0] SPIN_FLOOR = 17'd58982;
    localparam logic [16:0] SPIN_DECAY = 17'd65208;
    localparam logic signed [34:0] NEAR_FLOOR = 35'sd3277;

    localparam longint unsigned LIM_NUM = 64'd128843776;
    localparam logic [20:0] VMIN = 21'd655360;
    localparam logic [20:0] VMAX = 21'd1966080;

    localparam int unsigned ROOT_STAGES = 32;
    localparam int unsigned DIV_STAGES  = 17;

    typedef logic [20:0] lim_tab_t [256];

    typedef struct packed {
        logic [16:0] damping;
        logic [16:0] restitution;
        logic [16:0] friction;
        logic [31:0] floor_level;
        logic [16:0] time_step;
        logic [31:0] gdt;
        logic [20:0] lim;
        logic [41:0] lim2;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][31:0] v;
        logic [2:0][31:0] w;
        logic [2:0][31:0] turn;
        logic [16:0]      radius;
        logic             near;
        logic             ovr;
    } item_t;

    function automatic logic signed [32:0] sv33(input logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [32:0] uv33(input logic [16:0] v);
        return {16'b0, v};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -50'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Q16.16 product, rounded half up (floor after adding one half), saturated.
    function automatic logic [31:0] mulq(input logic signed [32:0] a,
                                         input logic signed [32:0] b);
        logic signed [65:0] t;
        logic signed [49:0] r;
        t = a * b + 66'sd32768;
        r = t[65:16];
        return sat32(r);
    endfunction

    // The quotient is found by shift and subtract; the numerator is below 2^27.
    function automatic lim_tab_t build_lim_tab();
        lim_tab_t t;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned dv;
        for (int i = 0; i < 256; i++)
        begin
            if (i == 0)
            begin
                q = 64'(VMAX);
            end
            else
            begin
                q   = 64'd0;
                rem = LIM_NUM;
                dv  = 64'(i);
                for (int b = 27; b >= 0; b--)
                begin
                    if ((rem >> b) >= dv)
                    begin
                        rem = rem - (dv << b);
                        q   = q | (64'd1 << b);
                    end
                end
            end
            if (q > 64'(VMAX)) q = 64'(VMAX);
            if (q < 64'(VMIN)) q = 64'(VMIN);
            t[i] = q[20:0];
        end
        return t;
    endfunction

    localparam lim_tab_t LIM_TAB = build_lim_tab();

    // Speed limit for a step length; steps of 256 and above always give the floor value.
    function automatic logic [20:0] lim_of(input logic [16:0] ts);
        if (ts[16:8] != '0) return VMIN;
        return LIM_TAB[ts[7:0]];
    endfunction

    localparam logic [31:0] GDT_RST  = mulq(sv33(GRAVITY_RST), uv33(TIME_STEP_RST));
    localparam logic [20:0] LIM_RST  = lim_of(TIME_STEP_RST);
    localparam logic [41:0] LIM2_RST = 42'(LIM_RST) * 42'(LIM_RST);

endpackage

// ===== hw/rtl/pis_if.sv =====
interface pis_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] spin_x;
    logic [31:0] spin_y;
    logic [31:0] spin_z;
    logic [16:0] radius;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    spin_x, spin_y, spin_z, radius, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  spin_x, spin_y, spin_z, radius, output ready);
endinterface

interface pis_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_pos_x;
    logic [31:0] new_pos_y;
    logic [31:0] new_pos_z;
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic [31:0] new_vel_z;
    logic [31:0] new_spin_x;
    logic [31:0] new_spin_y;
    logic [31:0] new_spin_z;
    logic [31:0] turn_x;
    logic [31:0] turn_y;
    logic [31:0] turn_z;

    modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                    new_vel_z, new_spin_x, new_spin_y, new_spin_z, turn_x, turn_y,
                    turn_z, input ready);
    modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, new_spin_x, new_spin_y, new_spin_z, turn_x, turn_y,
                  turn_z, output ready);
endinterface

// ===== hw/rtl/pis_cfg.sv =====
module pis_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pis_pkg::AW-1:0]    paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output pis_pkg::cfg_t             cfg
);
    import pis_pkg::*;

    logic [31:0] gravity_reg;
    logic [16:0] damping_reg;
    logic [16:0] restitution_reg;
    logic [16:0] friction_reg;
    logic [31:0] floor_reg;
    logic [16:0] ts_reg;
    logic [31:0] gdt_reg;
    logic [20:0] lim_reg;
    logic [41:0] lim2_reg;
    logic        wr;
    reg_idx_t    idx;

    assign wr     = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;

    // The gravity step product and the speed limit follow the written data directly,
    // so they are current at the same edge as the registers they derive from.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg     <= GRAVITY_RST;
            damping_reg     <= DAMPING_RST;
            restitution_reg <= RESTITUTION_RST;
            friction_reg    <= FRICTION_RST;
            floor_reg       <= FLOOR_RST;
            ts_reg          <= TIME_STEP_RST;
            gdt_reg         <= GDT_RST;
            lim_reg         <= LIM_RST;
            lim2_reg        <= LIM2_RST;
        end
        else
        begin
            lim2_reg <= 42'(lim_reg) * 42'(lim_reg);
            if (wr)
            begin
                unique case (idx)
                    REG_GRAVITY:
                    begin
                        gravity_reg <= pwdata;
                        gdt_reg     <= mulq(sv33(pwdata), uv33(ts_reg));
                    end
                    REG_DAMPING:     damping_reg     <= pwdata[16:0];
                    REG_RESTITUTION: restitution_reg <= pwdata[16:0];
                    REG_FRICTION:    friction_reg    <= pwdata[16:0];
                    REG_FLOOR:       floor_reg       <= pwdata;
                    REG_TIME_STEP:
                    begin
                        ts_reg  <= pwdata[16:0];
                        gdt_reg <= mulq(sv33(gravity_reg), uv33(pwdata[16:0]));
                        lim_reg <= lim_of(pwdata[16:0]);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GRAVITY:     prdata = gravity_reg;
            REG_DAMPING:     prdata = {15'b0, damping_reg};
            REG_RESTITUTION: prdata = {15'b0, restitution_reg};
            REG_FRICTION:    prdata = {15'b0, friction_reg};
            REG_FLOOR:       prdata = floor_reg;
            REG_TIME_STEP:   prdata = {15'b0, ts_reg};
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.damping     = damping_reg;
        cfg.restitution = restitution_reg;
        cfg.friction    = friction_reg;
        cfg.floor_level = floor_reg;
        cfg.time_step   = ts_reg;
        cfg.gdt         = gdt_reg;
        cfg.lim         = lim_reg;
        cfg.lim2        = lim2_reg;
    end
endmodule

// ===== hw/rtl/pis_front.sv =====
module pis_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  pis_pkg::item_t   in_item,
    input  pis_pkg::cfg_t    cfg,
    output logic             out_vld,
    output pis_pkg::item_t   out_item,
    output logic [63:0]      ssq
);
    import pis_pkg::*;

    logic [2:0]        vld_reg;
    item_t             s1_reg, s1_next;
    item_t             s2_reg, s2_next;
    item_t             s3_reg, s3_next;
    logic [2:0][63:0]  sq_reg, sq_next;
    logic [63:0]       ssq_reg, ssq_next;
    logic signed [34:0] near_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            sq_reg  <= sq_next;
            s3_reg  <= s3_next;
            ssq_reg <= ssq_next;
        end
    end

    // Gravity, the near-floor test and the near-floor spin scaling.
    always_comb
    begin
        s1_next = in_item;
        s1_next.v[1] = sat32(50'(sv33(in_item.v[1])) + 50'(sv33(cfg.gdt)));
        near_dist = 35'(sv33(in_item.p[1])) - 35'(uv33(in_item.radius))
                  - 35'(sv33(cfg.floor_level));
        s1_next.near = near_dist < NEAR_FLOOR;
        for (int i = 0; i < 3; i++)
        begin
            if (s1_next.near) s1_next.w[i] = mulq(sv33(in_item.w[i]), uv33(SPIN_FLOOR));
        end
    end

    // Squared velocity components, rotation increment and spin decay.
    always_comb
    begin
        logic [31:0] a;
        s2_next = s1_reg;
        for (int i = 0; i < 3; i++)
        begin
            a = s1_reg.v[i][31] ? (32'd0 - s1_reg.v[i]) : s1_reg.v[i];
            sq_next[i]     = {32'b0, a} * {32'b0, a};
            s2_next.turn[i] = mulq(sv33(s1_reg.w[i]), uv33(cfg.time_step));
            s2_next.w[i]    = mulq(sv33(s1_reg.w[i]), uv33(SPIN_DECAY));
        end
    end

    // Three squares of at most 2^62 each cannot carry out of 64 bits.
    always_comb
    begin
        s3_next     = s2_reg;
        ssq_next    = sq_reg[0] + sq_reg[1] + sq_reg[2];
        s3_next.ovr = ssq_next > {22'b0, cfg.lim2};
    end

    assign out_vld  = vld_reg[2];
    assign out_item = s3_reg;
    assign ssq      = ssq_reg;
endmodule

// ===== hw/rtl/pis_root.sv =====
module pis_root (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  pis_pkg::item_t   in_item,
    input  logic [63:0]      ssq,
    output logic             out_vld,
    output pis_pkg::item_t   out_item,
    output logic [31:0]      root
);
    import pis_pkg::*;

    logic        vld_reg  [ROOT_STAGES];
    item_t       item_reg [ROOT_STAGES];
    logic [63:0] x_reg    [ROOT_STAGES];
    logic [63:0] res_reg  [ROOT_STAGES];

    // One result bit per stage, most significant first.
    for (genvar k = 0; k < ROOT_STAGES; k++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic        v_in;
        item_t       it_in;
        logic [63:0] x_in;
        logic [63:0] res_in;
        logic [63:0] trial;

        if (k == 0)
        begin : g_first
            assign v_in   = in_vld;
            assign it_in  = in_item;
            assign x_in   = ssq;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign v_in   = vld_reg[k-1];
            assign it_in  = item_reg[k-1];
            assign x_in   = x_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) vld_reg[k] <= 1'b0;
            else if (en) vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= it_in;
                if (x_in >= trial)
                begin
                    x_reg[k]   <= x_in - trial;
                    res_reg[k] <= (res_in >> 1) + BIT;
                end
                else
                begin
                    x_reg[k]   <= x_in;
                    res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_STAGES-1];
    assign out_item = item_reg[ROOT_STAGES-1];
    assign root     = res_reg[ROOT_STAGES-1][31:0];
endmodule

// ===== hw/rtl/pis_div.sv =====
module pis_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  pis_pkg::item_t   in_item,
    input  logic [31:0]      root,
    input  pis_pkg::cfg_t    cfg,
    output logic             out_vld,
    output pis_pkg::item_t   out_item,
    output logic [16:0]      scale
);
    import pis_pkg::*;

    logic        vld_reg  [DIV_STAGES];
    item_t       item_reg [DIV_STAGES];
    logic [36:0] rem_reg  [DIV_STAGES];
    logic [31:0] den_reg  [DIV_STAGES];
    logic [16:0] q_reg    [DIV_STAGES];

    // Restoring division of limit * 2^16 by the speed. The quotient only matters when
    // the speed is above the limit, and then it never exceeds 2^16.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        localparam int SH = DIV_STAGES - 1 - k;
        logic        v_in;
        item_t       it_in;
        logic [36:0] rem_in;
        logic [31:0] den_in;
        logic [16:0] q_in;
        logic [48:0] dsh;

        if (k == 0)
        begin : g_first
            assign v_in   = in_vld;
            assign it_in  = in_item;
            assign rem_in = {cfg.lim, 16'b0};
            assign den_in = (root == '0) ? 32'd1 : root;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign v_in   = vld_reg[k-1];
            assign it_in  = item_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign dsh = {17'b0, den_in} << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) vld_reg[k] <= 1'b0;
            else if (en) vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= it_in;
                den_reg[k]  <= den_in;
                if ({12'b0, rem_in} >= dsh)
                begin
                    rem_reg[k] <= rem_in - dsh[36:0];
                    q_reg[k]   <= q_in | (17'd1 << SH);
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    q_reg[k]   <= q_in;
                end
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_item = item_reg[DIV_STAGES-1];
    assign scale    = q_reg[DIV_STAGES-1];
endmodule

// ===== hw/rtl/pis_back.sv =====
module pis_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  pis_pkg::item_t   in_item,
    input  logic [16:0]      scale,
    input  pis_pkg::cfg_t    cfg,
    output logic             out_vld,
    output pis_pkg::item_t   out_item
);
    import pis_pkg::*;

    logic [5:0]       vld_reg;
    item_t            b1_reg, b1_next;
    item_t            b2_reg, b2_next;
    item_t            b3_reg, b3_next;
    item_t            b4_reg;
    logic [2:0][31:0] dp_reg, dp_next;
    item_t            b5_reg, b5_next;
    item_t            b6_reg, b6_next;
    logic             pen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[4:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
            b4_reg <= b3_reg;
            dp_reg <= dp_next;
            b5_reg <= b5_next;
            b6_reg <= b6_next;
        end
    end

    always_comb
    begin
        b1_next = in_item;
        b2_next = b1_reg;
        b3_next = b2_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (in_item.ovr) b1_next.v[i] = mulq(sv33(in_item.v[i]), uv33(scale));
            b2_next.v[i] = mulq(sv33(b1_reg.v[i]), uv33(cfg.damping));
            dp_next[i]   = mulq(sv33(b3_reg.v[i]), uv33(cfg.time_step));
        end
        if (b2_reg.near)
        begin
            b3_next.v[0] = mulq(sv33(b2_reg.v[0]), uv33(cfg.friction));
            b3_next.v[2] = mulq(sv33(b2_reg.v[2]), uv33(cfg.friction));
        end
    end

    always_comb
    begin
        b5_next = b4_reg;
        for (int i = 0; i < 3; i++)
        begin
            b5_next.p[i] = sat32(50'(sv33(b4_reg.p[i])) + 50'(sv33(dp_reg[i])));
        end
    end

    // Floor snap and bounce.
    always_comb
    begin
        b6_next = b5_reg;
        pen = (35'(sv33(b5_reg.p[1])) - 35'(uv33(b5_reg.radius)))
            < 35'(sv33(cfg.floor_level));
        if (pen)
        begin
            b6_next.p[1] = sat32(50'(sv33(cfg.floor_level)) + 50'(uv33(b5_reg.radius)));
            b6_next.v[1] = mulq(-sv33(b5_reg.v[1]), uv33(cfg.restitution));
        end
    end

    assign out_vld  = vld_reg[5];
    assign out_item = b6_reg;
endmodule

// ===== hw/rtl/particle_integrate_step.sv =====
// An accepted input transaction passes the front, root, divider and back stages to dout.
// Throughput: one particle per cycle while dout is not stalled; the speed root (32 stages,
// one result bit each) and the limit divider (17 stages, one quotient bit each) set the depth.
// Reset: rst_n is asynchronous and active low; it clears every valid bit and loads
// the register reset values, so the block takes a transaction in the first cycle after.
module particle_integrate_step (
    input  logic                      clk,
    input  logic                      rst_n,
    pis_in_if.sink                    din,
    pis_out_if.source                 dout,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pis_pkg::AW-1:0]    paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import pis_pkg::*;

    cfg_t        cfg;
    logic        en;
    item_t       in_item;
    logic        f_vld, r_vld, d_vld, b_vld;
    item_t       f_item, r_item, d_item, b_item;
    logic [63:0] ssq;
    logic [31:0] root;
    logic [16:0] scale;

    // The whole pipeline moves together. It advances whenever the output register is
    // empty or its transaction is being taken, so a new particle enters while earlier
    // ones are still in flight, and a stall freezes every stage in place.
    assign en        = !b_vld || dout.ready;
    assign din.ready = en;

    always_comb
    begin
        in_item        = '0;
        in_item.p[0]   = din.pos_x;
        in_item.p[1]   = din.pos_y;
        in_item.p[2]   = din.pos_z;
        in_item.v[0]   = din.vel_x;
        in_item.v[1]   = din.vel_y;
        in_item.v[2]   = din.vel_z;
        in_item.w[0]   = din.spin_x;
        in_item.w[1]   = din.spin_y;
        in_item.w[2]   = din.spin_z;
        in_item.radius = din.radius;
    end

    pis_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: gravity, floor proximity, spin, squared speed against the squared limit.
    pis_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (din.valid),
        .in_item  (in_item),
        .cfg      (cfg),
        .out_vld  (f_vld),
        .out_item (f_item),
        .ssq      (ssq)
    );

    // Integer square root of the squared speed.
    pis_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .in_item  (f_item),
        .ssq      (ssq),
        .out_vld  (r_vld),
        .out_item (r_item),
        .root     (root)
    );

    // Velocity scale factor, limit / speed in unsigned Q1.16.
    pis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (r_vld),
        .in_item  (r_item),
        .root     (root),
        .cfg      (cfg),
        .out_vld  (d_vld),
        .out_item (d_item),
        .scale    (scale)
    );

    // Back: clamp, damping, friction, integration and floor response. Its last stage
    // is the output register.
    pis_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (d_vld),
        .in_item  (d_item),
        .scale    (scale),
        .cfg      (cfg),
        .out_vld  (b_vld),
        .out_item (b_item)
    );

    assign dout.valid      = b_vld;
    assign dout.new_pos_x  = b_item.p[0];
    assign dout.new_pos_y  = b_item.p[1];
    assign dout.new_pos_z  = b_item.p[2];
    assign dout.new_vel_x  = b_item.v[0];
    assign dout.new_vel_y  = b_item.v[1];
    assign dout.new_vel_z  = b_item.v[2];
    assign dout.new_spin_x = b_item.w[0];
    assign dout.new_spin_y = b_item.w[1];
    assign dout.new_spin_z = b_item.w[2];
    assign dout.turn_x     = b_item.turn[0];
    assign dout.turn_y     = b_item.turn[1];
    assign dout.turn_z     = b_item.turn[2];
endmodule

// ===== hw/rtl/pis_checker.sv =====
module pis_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] new_pos_x,
    input logic [31:0] new_vel_y,
    input logic [31:0] turn_z,
    input logic        pready
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(new_pos_x) && $stable(new_vel_y)
                                    && $stable(turn_z))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow the output register");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port inserted a wait state");
endmodule

bind particle_integrate_step pis_checker u_pis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .new_pos_x (dout.new_pos_x),
    .new_vel_y (dout.new_vel_y),
    .turn_z    (dout.turn_z),
    .pready    (pready)
);
